[src/ket_pkg.sv]
package ket_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_W         = 32;
  localparam int PAYLOAD_W     = 64;
  localparam int CAP_W         = 5;
  localparam int COUNT_OUT_W   = 5;
  localparam int STATUS_W      = 3;
  localparam int CMD_W         = 2;
  localparam int WORD_W        = KEY_W + PAYLOAD_W;
  localparam int IN_DATA_W     = 2 * KEY_W + PAYLOAD_W;
  localparam int OUT_DATA_W    = STATUS_W + KEY_W + PAYLOAD_W + COUNT_OUT_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CONFLICT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic scan_cmp;
    logic shift_start;
    logic rd_next;
    logic shift_wr;
    logic commit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic full;
    logic scan_end;
    logic match_found;
    logic shift_end;
    logic out_free;
  } dp_sts_t;

endpackage

[src/keyed_entry_table_unit.sv]
// Keyed entry table: up to TABLE_DEPTH entries of a 32-bit key and a 64-bit
// payload, kept in insertion order, driven by add, delete, update and get.
// Slave channel: one command per transaction, the opcode on s_tuser, the key,
// replacement key and payload on s_tdata. Master channel: one result per
// command with status, the entry found by get (zero otherwise) and the entry
// count after the command.
// The search reads the entries in turn through the single read port of the
// entry RAM, with a read state and a compare state per entry; delete then
// moves the later entries down, again with a read and a write state per
// entry. An add to a full table ends the search at once. The next command
// can be taken in the cycle after the result is loaded.
// The capacity register may be written on any cycle the block is idle.
// Reset empties the table and sets the capacity to sixteen; no clearing pass.
// The result sits in an output register: a stalled receiver holds it, the
// next command is still taken and searched, and the block waits to load its
// result until the previous one has gone.
module keyed_entry_table_unit #(
  parameter int TABLE_DEPTH = ket_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ket_pkg::IN_DATA_W-1:0]  s_tdata,   // key, new_key, payload
  input  logic [ket_pkg::CMD_W-1:0]      s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ket_pkg::OUT_DATA_W-1:0] m_tdata,   // status, found_key,
                                                    // found_payload, entry_count
  input  logic                           cfg_wr_en,
  input  logic [ket_pkg::CAP_W-1:0]      cfg_wr_data
);

  import ket_pkg::*;

  ctrl_t   ctrl;
  dp_sts_t sts;

  ket_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .ctrl    (ctrl)
  );

  ket_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .ctrl       (ctrl),
    .sts        (sts)
  );

  // a result never overwrites one that is still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  // one command at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while busy");

  // every shift write follows a read of the next entry
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift_wr |-> $past(ctrl.rd_next))
    else $error("shift write without preceding read");

  // a loaded result shows up on the master side
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> m_tvalid)
    else $error("committed result not presented");

endmodule

[src/ket_ram.sv]
module ket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ket_ctrl.sv]
module ket_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ket_pkg::dp_sts_t sts,
  output ket_pkg::ctrl_t   ctrl
);

  import ket_pkg::*;

  state_t state;
  state_t state_next;
  logic   scan_done;
  logic   go_shift;

  // search ends at the table end, on a first hit (update scans everything
  // for conflicts), or right away when an add finds the table full
  assign scan_done = sts.scan_end ||
                     (sts.op != CMD_UPDATE && sts.match_found) ||
                     (sts.op == CMD_ADD && sts.full);
  assign go_shift  = sts.op == CMD_DELETE && sts.match_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (scan_done) begin
          state_next = go_shift ? S_SHIFT_RD : S_FINISH;
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_next = S_SCAN_RD;
      S_SHIFT_RD: begin
        state_next = sts.shift_end ? S_FINISH : S_SHIFT_WR;
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready       = 1'b1;
        ctrl.load_item = s_tvalid;
      end
      S_SCAN_RD:  ctrl.shift_start = scan_done && go_shift;
      S_SCAN_CMP: ctrl.scan_cmp = 1'b1;
      S_SHIFT_RD: ctrl.rd_next = 1'b1;
      S_SHIFT_WR: ctrl.shift_wr = 1'b1;
      S_FINISH:   ctrl.commit = sts.out_free;
      default: begin
        ctrl     = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[src/ket_datapath.sv]
module ket_datapath #(
  parameter int TABLE_DEPTH = ket_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ket_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [ket_pkg::CMD_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ket_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_wr_en,
  input  logic [ket_pkg::CAP_W-1:0]        cfg_wr_data,
  input  ket_pkg::ctrl_t                   ctrl,
  output ket_pkg::dp_sts_t                 sts
);

  import ket_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  cmd_t                 op;
  logic [KEY_W-1:0]     item_key;
  logic [KEY_W-1:0]     item_new_key;
  logic [PAYLOAD_W-1:0] item_payload;
  logic [CW-1:0]        idx;
  logic [CW:0]          idx_inc;
  logic [AW-1:0]        pos;
  logic                 match_found;
  logic                 conflict;
  logic [WORD_W-1:0]    found_word;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CAP_W-1:0]     capacity;

  logic [MW-1:0]        cap_ext;
  logic [MW-1:0]        eff_cap;
  logic                 full;

  logic [WORD_W-1:0]    rd_data;
  logic [KEY_W-1:0]     rd_key;
  logic [AW-1:0]        raddr;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;

  status_t              res_status_next;
  logic                 commit_wr;
  logic [AW-1:0]        commit_addr;
  logic [WORD_W-1:0]    commit_data;
  logic                 get_hit;

  status_t              res_status;
  logic [KEY_W-1:0]     res_key;
  logic [PAYLOAD_W-1:0] res_payload;
  logic [COUNT_OUT_W-1:0] res_count;

  assign idx_inc = {1'b0, idx} + (CW+1)'(1);
  assign rd_key  = rd_data[KEY_W-1:0];

  assign cap_ext = MW'(capacity);
  assign eff_cap = (cap_ext > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : cap_ext;
  assign full    = MW'(count) >= eff_cap;

  assign sts.op          = op;
  assign sts.full        = full;
  assign sts.scan_end    = idx >= count;
  assign sts.match_found = match_found;
  assign sts.shift_end   = idx_inc >= {1'b0, count};
  assign sts.out_free    = !m_tvalid || m_tready;

  assign raddr = ctrl.rd_next ? idx_inc[AW-1:0] : idx[AW-1:0];

  // result of the command, settled once the search and any shift are over
  always_comb begin
    res_status_next = ST_OK;
    commit_wr       = 1'b0;
    commit_addr     = idx[AW-1:0];
    commit_data     = {item_payload, item_key};
    count_next      = count;
    get_hit         = 1'b0;
    unique case (op)
      CMD_ADD: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else if (match_found) begin
          res_status_next = ST_DUP;
        end else begin
          commit_wr   = 1'b1;
          commit_addr = count[AW-1:0];
          count_next  = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (!match_found) begin
          res_status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CW'(1);
        end
      end
      CMD_UPDATE: begin
        if (conflict) begin
          res_status_next = ST_CONFLICT;
        end else if (!match_found) begin
          res_status_next = ST_NOT_FOUND;
        end else begin
          commit_wr   = 1'b1;
          commit_addr = pos;
          commit_data = {item_payload, item_new_key};
        end
      end
      CMD_GET: begin
        if (!match_found) begin
          res_status_next = ST_NOT_FOUND;
        end else begin
          get_hit = 1'b1;
        end
      end
      default: res_status_next = ST_OK;
    endcase
  end

  assign ram_we    = ctrl.shift_wr || (ctrl.commit && commit_wr);
  assign ram_waddr = ctrl.shift_wr ? idx[AW-1:0] : commit_addr;
  assign ram_wdata = ctrl.shift_wr ? rd_data : commit_data;

  ket_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (ctrl.commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      op           <= cmd_t'(s_tuser);
      item_key     <= s_tdata[KEY_W-1:0];
      item_new_key <= s_tdata[2*KEY_W-1:KEY_W];
      item_payload <= s_tdata[IN_DATA_W-1:2*KEY_W];
      idx          <= '0;
      match_found  <= 1'b0;
      conflict     <= 1'b0;
    end else if (ctrl.scan_cmp) begin
      // keep only the first hit
      if (!match_found && rd_key == item_key) begin
        match_found <= 1'b1;
        pos         <= idx[AW-1:0];
        found_word  <= rd_data;
      end
      if (op == CMD_UPDATE && rd_key == item_new_key && rd_key != item_key) begin
        conflict <= 1'b1;
      end
      idx <= idx + CW'(1);
    end else if (ctrl.shift_start) begin
      idx <= CW'(pos);
    end else if (ctrl.shift_wr) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_status  <= res_status_next;
      res_key     <= get_hit ? found_word[KEY_W-1:0] : '0;
      res_payload <= get_hit ? found_word[WORD_W-1:KEY_W] : '0;
      res_count   <= COUNT_OUT_W'(count_next);
    end
  end

  assign m_tdata = {res_count, res_payload, res_key, res_status};

endmodule
